FILE: hdl/utf8_to_utf16_crlf_transcoder_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the UTF-8 to UTF-16 transcoder
// Shared shorthand for the concurrent checks of the transcoder.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_CRLF_TRANSCODER_TOP_MACROS_SVH
`define UTF8_TO_UTF16_CRLF_TRANSCODER_TOP_MACROS_SVH

// Checked on every edge out of reset.
`define U8U16_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define U8U16_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// Transcoder package
// Types and constants shared by the transcoder and its checker.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	typedef logic [15:0] unit_t;
	typedef logic [20:0] code_t;

	localparam int    MAX_UNITS  = 6;
	localparam int    CNT_W      = 3;

	localparam unit_t REPL_UNIT  = 16'hFFFD;
	localparam unit_t HI_SURR    = 16'hD800;
	localparam unit_t LO_SURR    = 16'hDC00;
	localparam unit_t CR_UNIT    = 16'h000D;
	localparam unit_t LF_UNIT    = 16'h000A;
	localparam unit_t TERM_UNIT  = 16'h0000;

	localparam logic [7:0] CR_BYTE = 8'h0D;
	localparam logic [7:0] LF_BYTE = 8'h0A;

	localparam code_t MIN_CLASS1 = 21'h000080;
	localparam code_t MIN_CLASS2 = 21'h000800;
	localparam code_t MIN_CLASS3 = 21'h010000;
	localparam code_t MAX_CODE   = 21'h10FFFF;
	localparam code_t BMP_MAX    = 21'h00FFFF;
	localparam code_t SURR_LOW   = 21'h00D800;
	localparam code_t SURR_HIGH  = 21'h00DFFF;

	localparam logic [1:0] CLASS_TWO   = 2'd1;
	localparam logic [1:0] CLASS_THREE = 2'd2;
	localparam logic [1:0] CLASS_FOUR  = 2'd3;

endpackage

FILE: hdl/utf8_to_utf16_crlf_transcoder_top.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder with CR LF newlines
// Decodes UTF-8 bytes into UTF-16 code units, turns every newline into
// CR LF, replaces bad input by U+FFFD and ends each text with a zero unit.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                | tlast
//  s_*     | in        | [7:0] in_byte        | end_of_text
//  m_*     | out       | [15:0] code_unit     | final_unit
//
//  One byte enters the input register per cycle while s_tready is high;
//  the decode logic fills a unit buffer of up to six units, which drains
//  one unit per cycle while m_tready is high. A byte waits in the input
//  register until the buffer is free, then its units load into the buffer.
//  The buffer loads its next set in the cycle its last unit is taken.
//  arst_n clears the decoder state and empties both registers.
module utf8_to_utf16_crlf_transcoder_top
	import u8u16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] code_unit
	output logic        m_tlast    // final_unit
);

	// input register
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	// decoder state
	code_t            pc_q;
	logic [1:0]       exp_q;
	logic [1:0]       taken_q;
	logic [1:0]       cls_q;
	logic             after_cr_q;

	// unit buffer
	unit_t            units_q [MAX_UNITS];
	logic [CNT_W-1:0] cnt_q;
	logic             term_q;

	logic             buf_free;
	logic             advance;

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = units_q[0];
	assign m_tlast  = term_q && (cnt_q == CNT_W'(1));

	assign buf_free = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && m_tready);
	assign advance  = valid_s1 && buf_free;
	assign s_tready = !valid_s1 || buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// ------------------------------------------------------------------
	// Decode
	// ------------------------------------------------------------------
	logic             cont;
	logic             in_seq;
	code_t            cp_acc;
	logic [1:0]       taken_inc;

	code_t            min_code;
	code_t            surr_off;
	logic             fin_bad;
	logic [1:0]       fin_m;
	unit_t            fin_u0;
	unit_t            fin_u1;

	logic [1:0]       lead_m;
	unit_t            lead_u0;
	unit_t            lead_u1;
	logic [1:0]       lead_exp;
	code_t            lead_pc;

	logic [CNT_W-1:0] f_cnt;
	logic [1:0]       m_cnt;
	logic [CNT_W-1:0] g_cnt;
	unit_t            mid0;
	unit_t            mid1;
	code_t            pc_n;
	logic [1:0]       exp_n;
	logic [1:0]       taken_n;
	logic [1:0]       cls_n;
	logic             after_cr_n;

	logic [CNT_W-1:0] end_fm;
	logic [CNT_W-1:0] end_fmg;
	logic [CNT_W-1:0] total;
	unit_t            units_d [MAX_UNITS];

	assign cont      = (byte_s1[7:6] == 2'b10);
	assign in_seq    = (exp_q != 2'd0);
	assign cp_acc    = {pc_q[14:0], byte_s1[5:0]};
	assign taken_inc = taken_q + 2'd1;

	// Checks on a completed sequence
	always_comb begin
		case (cls_q)
			CLASS_TWO:   min_code = MIN_CLASS1;
			CLASS_THREE: min_code = MIN_CLASS2;
			default:     min_code = MIN_CLASS3;
		endcase
		surr_off = cp_acc - MIN_CLASS3;
		fin_bad  = (cp_acc < min_code) || (cp_acc > MAX_CODE) ||
			((cp_acc >= SURR_LOW) && (cp_acc <= SURR_HIGH));
		fin_u1   = LO_SURR + {6'd0, surr_off[9:0]};
		if (fin_bad) begin
			fin_m  = 2'd1;
			fin_u0 = REPL_UNIT;
		end else if (cp_acc <= BMP_MAX) begin
			fin_m  = 2'd1;
			fin_u0 = cp_acc[15:0];
		end else begin
			fin_m  = 2'd2;
			fin_u0 = HI_SURR + {6'd0, surr_off[19:10]};
		end
	end

	// A byte taken as a lead (or a plain ASCII byte)
	always_comb begin
		lead_m   = 2'd0;
		lead_u0  = REPL_UNIT;
		lead_u1  = LF_UNIT;
		lead_exp = 2'd0;
		lead_pc  = '0;
		if (!byte_s1[7]) begin
			if (byte_s1 == CR_BYTE) begin
				lead_m  = 2'd2;
				lead_u0 = CR_UNIT;
			end else if (byte_s1 == LF_BYTE) begin
				// An LF straight after a CR is already covered by that CR.
				lead_m  = after_cr_q ? 2'd0 : 2'd2;
				lead_u0 = CR_UNIT;
			end else begin
				lead_m  = 2'd1;
				lead_u0 = {8'd0, byte_s1};
			end
		end else if (byte_s1[7:5] == 3'b110) begin
			lead_exp = CLASS_TWO;
			lead_pc  = {16'd0, byte_s1[4:0]};
		end else if (byte_s1[7:4] == 4'b1110) begin
			lead_exp = CLASS_THREE;
			lead_pc  = {17'd0, byte_s1[3:0]};
		end else if (byte_s1[7:3] == 5'b11110) begin
			lead_exp = CLASS_FOUR;
			lead_pc  = {18'd0, byte_s1[2:0]};
		end else begin
			lead_m = 2'd1;
		end
	end

	// Units in order: broken-sequence fill, decoded units, end-of-text fill,
	// terminator.
	always_comb begin
		f_cnt   = '0;
		m_cnt   = 2'd0;
		g_cnt   = '0;
		mid0    = REPL_UNIT;
		mid1    = REPL_UNIT;
		pc_n    = pc_q;
		exp_n   = exp_q;
		taken_n = taken_q;
		cls_n   = cls_q;
		if (in_seq && cont) begin
			pc_n    = cp_acc;
			taken_n = taken_inc;
			if (taken_inc >= exp_q) begin
				m_cnt   = fin_m;
				mid0    = fin_u0;
				mid1    = fin_u1;
				pc_n    = '0;
				exp_n   = 2'd0;
				taken_n = 2'd0;
				cls_n   = 2'd0;
			end
		end else begin
			if (in_seq) begin
				f_cnt = {1'b0, taken_q} + CNT_W'(1);
			end
			m_cnt   = lead_m;
			mid0    = lead_u0;
			mid1    = lead_u1;
			pc_n    = lead_pc;
			exp_n   = lead_exp;
			taken_n = 2'd0;
			cls_n   = lead_exp;
		end
		after_cr_n = (byte_s1 == CR_BYTE);
		if (last_s1) begin
			if (exp_n != 2'd0) begin
				g_cnt = {1'b0, taken_n} + CNT_W'(1);
			end
			pc_n       = '0;
			exp_n      = 2'd0;
			taken_n    = 2'd0;
			cls_n      = 2'd0;
			after_cr_n = 1'b0;
		end
	end

	assign end_fm  = f_cnt + {1'b0, m_cnt};
	assign end_fmg = end_fm + g_cnt;
	assign total   = end_fmg + {{(CNT_W-1){1'b0}}, last_s1};

	always_comb begin
		logic [CNT_W-1:0] kk;
		logic [CNT_W-1:0] rel;
		for (int k = 0; k < MAX_UNITS; k++) begin
			kk  = CNT_W'(k);
			rel = kk - f_cnt;
			if (kk < f_cnt) begin
				units_d[k] = REPL_UNIT;
			end else if (kk < end_fm) begin
				units_d[k] = rel[0] ? mid1 : mid0;
			end else if (kk < end_fmg) begin
				units_d[k] = REPL_UNIT;
			end else begin
				units_d[k] = TERM_UNIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= '0;
			exp_q      <= 2'd0;
			taken_q    <= 2'd0;
			cls_q      <= 2'd0;
			after_cr_q <= 1'b0;
		end else if (advance) begin
			pc_q       <= pc_n;
			exp_q      <= exp_n;
			taken_q    <= taken_n;
			cls_q      <= cls_n;
			after_cr_q <= after_cr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			term_q <= 1'b0;
		end else if (advance) begin
			cnt_q  <= total;
			term_q <= last_s1;
		end else if (m_tvalid && m_tready) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// The buffer drains from slot zero; each taken beat shifts it down.
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < MAX_UNITS; k++) begin
				units_q[k] <= units_d[k];
			end
		end else if (m_tvalid && m_tready) begin
			for (int k = 0; k < MAX_UNITS - 1; k++) begin
				units_q[k] <= units_q[k+1];
			end
		end
	end

endmodule

FILE: hdl/u8u16_checker.sv
// ----------------------------------------------------------------------------
// Transcoder port checker
// Watches the transcoder's ports and flags illegal output sequences.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_crlf_transcoder_top_macros.svh"

module u8u16_checker
	import u8u16_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,   // [7:0] in_byte
	input logic        s_tlast,   // end_of_text
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,   // [15:0] code_unit
	input logic        m_tlast    // final_unit
);

	// A stalled output beat keeps its contents.
	`U8U16_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output beat changed while stalled")

	// The final beat of a text carries the zero terminator.
	`U8U16_ASSERT(a_term_zero, m_tvalid && m_tlast |-> m_tdata == TERM_UNIT, "final beat is not a zero unit")

	// A high surrogate is always followed directly by a low surrogate.
	`U8U16_ASSERT(a_surr_pair, m_tvalid && m_tready && m_tdata[15:10] == HI_SURR[15:10] |=> m_tvalid && m_tdata[15:10] == LO_SURR[15:10], "high surrogate without its low half")

	// Nothing is offered while reset is held.
	`U8U16_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid, "output valid during reset")

endmodule

bind utf8_to_utf16_crlf_transcoder_top u8u16_checker u_chk (.*);

FILE: verif/utf16_unit_checker.sv
// ----------------------------------------------------------------------------
// UTF-16 unit checker for the transcoder
// Watches both stream channels, works out the code units that each accepted
// byte must give, and compares every unit leaving the block with the oldest
// unit still awaited.
// ----------------------------------------------------------------------------
module utf16_unit_checker
	import u8u16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // end_of_text
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [15:0] code_unit
	input  logic        m_tlast,   // final_unit
	output int          error_count,
	output int          units_pending
);

	typedef struct packed {
		unit_t code_unit;
		logic  final_unit;
	} unit_rec_t;

	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_TAG  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_TAG  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_TAG  = 8'hF0;

	unit_rec_t   awaited_units[$];
	unit_rec_t   oldest;

	code_t       partial_code;
	logic [1:0]  bytes_expected;
	logic [1:0]  bytes_taken;
	logic [1:0]  length_class;
	logic        after_cr;

	initial begin
		error_count    = 0;
		units_pending  = 0;
		partial_code   = '0;
		bytes_expected = '0;
		bytes_taken    = '0;
		length_class   = '0;
		after_cr       = 1'b0;
	end

	task automatic push_unit(input unit_t unit, input logic fin);
		unit_rec_t rec;
		rec.code_unit  = unit;
		rec.final_unit = fin;
		awaited_units.insert(awaited_units.size(), rec);
	endtask

	// One replacement for the lead and one for each continuation byte taken.
	task automatic flush_broken();
		for (int i = 0; i <= int'(bytes_taken); i++)
			push_unit(REPL_UNIT, 1'b0);
		partial_code   = '0;
		bytes_expected = '0;
		bytes_taken    = '0;
		length_class   = '0;
	endtask

	task automatic take_lead(input logic [7:0] b, input logic prev_cr);
		if (b[7] == 1'b0) begin
			if (b == CR_BYTE) begin
				push_unit(CR_UNIT, 1'b0);
				push_unit(LF_UNIT, 1'b0);
			end else if (b == LF_BYTE) begin
				if (!prev_cr) begin
					push_unit(CR_UNIT, 1'b0);
					push_unit(LF_UNIT, 1'b0);
				end
			end else begin
				push_unit(unit_t'(b), 1'b0);
			end
		end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
			bytes_expected = 2'd1;
			length_class   = CLASS_TWO;
			bytes_taken    = '0;
			partial_code   = code_t'(b[4:0]);
		end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
			bytes_expected = 2'd2;
			length_class   = CLASS_THREE;
			bytes_taken    = '0;
			partial_code   = code_t'(b[3:0]);
		end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
			bytes_expected = 2'd3;
			length_class   = CLASS_FOUR;
			bytes_taken    = '0;
			partial_code   = code_t'(b[2:0]);
		end else begin
			push_unit(REPL_UNIT, 1'b0);
		end
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic last);
		logic  prev_cr;
		code_t cp;
		code_t lowest;
		code_t offset;
		prev_cr  = after_cr;
		after_cr = (b == CR_BYTE);
		if (bytes_expected != 2'd0) begin
			if ((b & CONT_MASK) == CONT_TAG) begin
				partial_code = {partial_code[14:0], b[5:0]};
				bytes_taken  = bytes_taken + 2'd1;
				if (bytes_taken >= bytes_expected) begin
					cp     = partial_code;
					lowest = (length_class == CLASS_TWO)   ? MIN_CLASS1 :
					         (length_class == CLASS_THREE) ? MIN_CLASS2 : MIN_CLASS3;
					partial_code   = '0;
					bytes_expected = '0;
					bytes_taken    = '0;
					length_class   = '0;
					if (cp < lowest || cp > MAX_CODE || (cp >= SURR_LOW && cp <= SURR_HIGH)) begin
						push_unit(REPL_UNIT, 1'b0);
					end else if (cp <= BMP_MAX) begin
						push_unit(cp[15:0], 1'b0);
					end else begin
						offset = cp - MIN_CLASS3;
						push_unit(HI_SURR + unit_t'(offset[19:10]), 1'b0);
						push_unit(LO_SURR + unit_t'(offset[9:0]), 1'b0);
					end
				end
			end else begin
				// The offending byte starts afresh, newlines included.
				flush_broken();
				take_lead(b, prev_cr);
			end
		end else begin
			take_lead(b, prev_cr);
		end
		if (last) begin
			if (bytes_expected != 2'd0)
				flush_broken();
			push_unit(TERM_UNIT, 1'b1);
			after_cr = 1'b0;
		end
	endtask

	// The input beat is handled first; its units cannot leave in the same cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (awaited_units.size() == 0) begin
					$error("unexpected beat: code_unit %h final_unit %b", m_tdata, m_tlast);
					error_count++;
				end else begin
					oldest = awaited_units.pop_front();
					if (m_tdata !== oldest.code_unit) begin
						$error("code_unit mismatch: expected %h, actual %h",
						       oldest.code_unit, m_tdata);
						error_count++;
					end
					if (m_tlast !== oldest.final_unit) begin
						$error("final_unit mismatch: expected %b, actual %b",
						       oldest.final_unit, m_tlast);
						error_count++;
					end
				end
			end
			units_pending = awaited_units.size();
		end
	end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Transcoder testbench
// Feeds the transcoder directed texts covering newlines and every kind of
// malformed sequence, then random texts of mostly well-formed UTF-8 with
// noise, under random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb;
	import u8u16_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BYTES = 300;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 20;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b1;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	int          error_count;
	int          units_pending;
	int          cycle_count = 0;
	bit          no_idle     = 1'b0;
	bit          hold_off    = 1'b0;

	byte_q_t     text;
	int          bytes_sent;
	int          kind;
	int          nchars;
	int          nclass;
	logic [20:0] cp;

	utf8_to_utf16_crlf_transcoder_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	utf16_unit_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.error_count  (error_count),
		.units_pending(units_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic append_byte(input logic [7:0] b);
		text.insert(text.size(), b);
	endtask

	// Called at a falling edge; returns at the falling edge after the last beat.
	task automatic send_text(input byte_q_t bytes);
		int gap;
		for (int i = 0; i < bytes.size(); i++) begin
			gap = no_idle ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= bytes[i];
			s_tlast  <= (i == bytes.size() - 1);
			do @(posedge clk); while (!s_tready);
			@(negedge clk);
		end
		bytes_sent += bytes.size();
	endtask

	// Output side: a random stall before each beat, once a long one.
	initial begin
		int stall;
		wait (arst_n === 1'b1 && cycle_count > 0);
		forever begin
			stall = hold_off ? LONG_HOLD : (no_idle ? 0 : $urandom_range(0, 4));
			hold_off = 1'b0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	initial begin
		bytes_sent = 0;
		// A real falling edge on the reset line, so the block's registers clear.
		#1 arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ASCII extremes, CR LF pair, lone LF, overlong, U+10FFFF, above range,
		// surrogate, bad leads, and a broken sequence whose breaker is a CR.
		text = '{8'h00, 8'h7F, CR_BYTE, LF_BYTE, LF_BYTE, 8'hC0, 8'h80,
		         8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF5, 8'h80, 8'h80, 8'h80,
		         8'hED, 8'hA0, 8'h80, 8'hBF, 8'hFF, 8'hE2, 8'h82, CR_BYTE,
		         LF_BYTE, 8'h41};
		send_text(text);
		// Text cut short inside a sequence.
		text = '{8'hE2, 8'h82};
		send_text(text);
		// LF after CR as the final byte.
		text = '{CR_BYTE, LF_BYTE};
		send_text(text);

		hold_off = 1'b1;
		while (bytes_sent < RANDOM_BYTES + 29) begin
			no_idle = ($urandom_range(0, 3) == 0);
			text.delete();
			nchars = $urandom_range(1, 10);
			for (int c = 0; c < nchars; c++) begin
				kind = $urandom_range(0, 99);
				if (kind < 30) begin
					append_byte(8'($urandom_range(0, 127)));
				end else if (kind < 38) begin
					append_byte(CR_BYTE);
				end else if (kind < 46) begin
					append_byte(LF_BYTE);
				end else if (kind < 56) begin
					cp = 21'($urandom_range(32'h80, 32'h7FF));
					append_byte({3'b110, cp[10:6]});
					append_byte({2'b10, cp[5:0]});
				end else if (kind < 66) begin
					cp = 21'($urandom_range(32'h800, 32'hFFFF));
					append_byte({4'b1110, cp[15:12]});
					append_byte({2'b10, cp[11:6]});
					append_byte({2'b10, cp[5:0]});
				end else if (kind < 76) begin
					cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
					append_byte({5'b11110, cp[20:18]});
					append_byte({2'b10, cp[17:12]});
					append_byte({2'b10, cp[11:6]});
					append_byte({2'b10, cp[5:0]});
				end else if (kind < 84) begin
					append_byte(8'($urandom));
				end else if (kind < 92) begin
					// Sequence that stops early.
					nclass = $urandom_range(1, 3);
					append_byte(nclass == 1 ? 8'($urandom_range(8'hC0, 8'hDF)) :
					            nclass == 2 ? 8'($urandom_range(8'hE0, 8'hEF)) :
					                          8'($urandom_range(8'hF0, 8'hF7)));
					repeat ($urandom_range(0, nclass - 1))
						append_byte({2'b10, 6'($urandom)});
				end else begin
					// Any lead with random continuations: overlong and out of range.
					nclass = $urandom_range(1, 3);
					append_byte(nclass == 1 ? 8'($urandom_range(8'hC0, 8'hDF)) :
					            nclass == 2 ? 8'($urandom_range(8'hE0, 8'hEF)) :
					                          8'($urandom_range(8'hF0, 8'hF7)));
					repeat (nclass)
						append_byte({2'b10, 6'($urandom)});
				end
			end
			send_text(text);
		end
		s_tvalid <= 1'b0;
		no_idle = 1'b0;

		while (units_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: utf8_to_utf16_crlf_transcoder_top.f
+incdir+hdl
hdl/u8u16_pkg.sv
hdl/utf8_to_utf16_crlf_transcoder_top.sv
hdl/u8u16_checker.sv
verif/utf16_unit_checker.sv
verif/tb.sv
